@@ design/atrs_pkg.sv @@
// Shared widths, fixed-point constants and stage enables for the affine matrix
// builder. No dependencies; imported by atrs_scale and affine_matrix_from_trs.
package atrs_pkg;

  // field widths
  localparam int unsigned TRANS_W = 32;
  localparam int unsigned QUAT_W  = 16;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned OUT_W   = 24;

  // internal widths: Q2.30 products, Q.30 matrix terms, Q.46 scaled terms
  localparam int unsigned PROD_W  = 2 * QUAT_W;
  localparam int unsigned TERM_W  = PROD_W + 2;
  localparam int unsigned MUL_W   = TERM_W + SCALE_W;
  localparam int unsigned FRAC_SH = 30;
  localparam int unsigned RND_W   = MUL_W - FRAC_SH;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 3 * TRANS_W + 4 * QUAT_W + 3 * SCALE_W;
  localparam int unsigned OUT_DATA_W = 9 * OUT_W + 3 * TRANS_W;

  // fixed-point constants
  localparam logic signed [TERM_W-1:0] ONE_Q30  = TERM_W'(64'd1 << FRAC_SH);
  localparam logic signed [MUL_W-1:0]  HALF_Q30 = MUL_W'(64'd1 << (FRAC_SH - 1));
  localparam logic signed [RND_W-1:0]  OUT_MAX  = RND_W'(64'sd8388607);
  localparam logic signed [RND_W-1:0]  OUT_MIN  = RND_W'(-64'sd8388608);

  // load enables of the two stages inside the scaling lane
  typedef struct packed {
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

@@ design/atrs_scale.sv @@
// One scaling lane: matrix term times scale, then round to Q8.16 and saturate.
// Two register stages. Depends on atrs_pkg.
module atrs_scale import atrs_pkg::*; (
  input  logic                      clk_i,
  input  stage_en_t                 en_i,
  input  logic signed [TERM_W-1:0]  term_i,
  input  logic signed [SCALE_W-1:0] scale_i,
  output logic signed [OUT_W-1:0]   res_o
);

  logic signed [MUL_W-1:0] prod_d, prod_q;
  logic signed [MUL_W-1:0] rnd;
  logic signed [RND_W-1:0] shr;
  logic signed [OUT_W-1:0] res_d, res_q;

  // stage 3: full-precision product in Q.46
  assign prod_d = term_i * scale_i;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      prod_q <= prod_d;
    end
  end

  // stage 4: round half up, drop 30 fraction bits, clamp to 24 bits
  always_comb begin
    rnd = prod_q + HALF_Q30;
    shr = rnd[MUL_W-1:FRAC_SH];
    if (shr > OUT_MAX) begin
      res_d = OUT_MAX[OUT_W-1:0];
    end else if (shr < OUT_MIN) begin
      res_d = OUT_MIN[OUT_W-1:0];
    end else begin
      res_d = shr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ design/affine_matrix_from_trs.sv @@
// Top level of the affine matrix builder: four-stage pipeline from a
// translation/rotation/scale pose to the upper three matrix rows.
// Depends on atrs_pkg and atrs_scale.
//
// Usage:
//   The slave stream carries one pose per transaction: translation (Q16.16),
//   quaternion (Q1.15) and per-axis scale (Q8.16). The master stream returns
//   one transaction per pose holding the nine scaled rotation terms
//   (Q8.16, saturated) and the translation as column 3, column-major.
//   Four register stages: m_axis_tvalid rises once a pose reaches stage 4,
//   and the matrix leaves the output register while m_axis_tready is high:
//     stage 1  nine 16x16 quaternion products
//     stage 2  the nine rotation matrix terms
//     stage 3  one 34x24 multiply per term by its column's scale
//     stage 4  round to nearest, saturate; this is the output register
//   Throughput is one pose per cycle while m_axis_tready is high; the multiply
//   stage sets the clock. When the receiver stalls, stages fill up behind the
//   output register and s_axis_tready drops only once all four stages hold a
//   pose. No pose is dropped or repeated. Reset clears the stage valid bits;
//   the pipeline is empty and ready right after reset.
module affine_matrix_from_trs import atrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // trans_x, trans_y, trans_z, quat_x, quat_y, quat_z, quat_w,
  // scale_x, scale_y, scale_z (lowest bit up)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z,
  // col3_x, col3_y, col3_z (lowest bit up)
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // input field unpack
  logic signed [QUAT_W-1:0]  quat_x, quat_y, quat_z, quat_w;
  logic signed [SCALE_W-1:0] scale_in [3];
  logic [3*TRANS_W-1:0]      trans_in;

  assign trans_in    = s_axis_tdata[95:0];
  assign quat_x      = s_axis_tdata[111:96];
  assign quat_y      = s_axis_tdata[127:112];
  assign quat_z      = s_axis_tdata[143:128];
  assign quat_w      = s_axis_tdata[159:144];
  assign scale_in[0] = s_axis_tdata[183:160];
  assign scale_in[1] = s_axis_tdata[207:184];
  assign scale_in[2] = s_axis_tdata[231:208];

  // stage control
  logic      v1_q, v2_q, v3_q, v4_q;
  logic      en1, en2;
  stage_en_t en;

  assign en.s4         = !v4_q || m_axis_tready;
  assign en.s3         = !v3_q || en.s4;
  assign en2           = !v2_q || en.s3;
  assign en1           = !v1_q || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1)   v1_q <= s_axis_tvalid;
      if (en2)   v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  // stage 1: pairwise quaternion products, Q2.30
  logic signed [PROD_W-1:0]  xx_q, xy_q, xz_q, xw_q, yy_q, yz_q, yw_q, zz_q, zw_q;
  logic signed [SCALE_W-1:0] scale1_q [3];
  logic [3*TRANS_W-1:0]      trans1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      xx_q     <= quat_x * quat_x;
      xy_q     <= quat_x * quat_y;
      xz_q     <= quat_x * quat_z;
      xw_q     <= quat_x * quat_w;
      yy_q     <= quat_y * quat_y;
      yz_q     <= quat_y * quat_z;
      yw_q     <= quat_y * quat_w;
      zz_q     <= quat_z * quat_z;
      zw_q     <= quat_z * quat_w;
      scale1_q <= scale_in;
      trans1_q <= trans_in;
    end
  end

  // stage 2: rotation matrix terms, Q.30 in 34 bits
  function automatic logic signed [TERM_W-1:0] twice_sum(
    input logic signed [PROD_W-1:0] a, input logic signed [PROD_W-1:0] b);
    logic signed [PROD_W:0] s;
    s = (PROD_W+1)'(a) + (PROD_W+1)'(b);
    return {s, 1'b0};
  endfunction

  function automatic logic signed [TERM_W-1:0] twice_diff(
    input logic signed [PROD_W-1:0] a, input logic signed [PROD_W-1:0] b);
    logic signed [PROD_W:0] s;
    s = (PROD_W+1)'(a) - (PROD_W+1)'(b);
    return {s, 1'b0};
  endfunction

  function automatic logic signed [TERM_W-1:0] one_minus(
    input logic signed [PROD_W-1:0] a, input logic signed [PROD_W-1:0] b);
    logic signed [TERM_W-1:0] t;
    t = twice_sum(a, b);
    return ONE_Q30 - t;
  endfunction

  logic signed [TERM_W-1:0]  term_d [9];
  logic signed [TERM_W-1:0]  term_q [9];
  logic signed [SCALE_W-1:0] scale2_q [3];
  logic [3*TRANS_W-1:0]      trans2_q;

  always_comb begin
    term_d[0] = one_minus(yy_q, zz_q);
    term_d[1] = twice_sum(xy_q, zw_q);
    term_d[2] = twice_diff(xz_q, yw_q);
    term_d[3] = twice_diff(xy_q, zw_q);
    term_d[4] = one_minus(xx_q, zz_q);
    term_d[5] = twice_sum(yz_q, xw_q);
    term_d[6] = twice_sum(xz_q, yw_q);
    term_d[7] = twice_diff(yz_q, xw_q);
    term_d[8] = one_minus(xx_q, yy_q);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      term_q   <= term_d;
      scale2_q <= scale1_q;
      trans2_q <= trans1_q;
    end
  end

  // stages 3 and 4: scale, round and saturate, one lane per matrix entry
  logic signed [OUT_W-1:0] res [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    atrs_scale u_scale (
      .clk_i   (clk_i),
      .en_i    (en),
      .term_i  (term_q[k]),
      .scale_i (scale2_q[k/3]),
      .res_o   (res[k])
    );
  end

  // translation rides alongside the scaling lanes
  logic [3*TRANS_W-1:0] trans3_q, trans4_q;

  always_ff @(posedge clk_i) begin
    if (en.s3) trans3_q <= trans2_q;
    if (en.s4) trans4_q <= trans3_q;
  end

  assign m_axis_tdata = {trans4_q, res[8], res[7], res[6], res[5], res[4],
                         res[3], res[2], res[1], res[0]};

  // checks
  a_ready_low_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && !m_axis_tready))
    else $error("input stalled while pipeline has room");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted pose missing from stage 1");

  a_s3_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en.s4) |=> v4_q)
    else $error("pose lost between multiply stage and output");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !v3_q) |=> !m_axis_tvalid)
    else $error("output repeated after drain");

endmodule
